@@ hdl/gbn_pkg.sv @@
// package: types, constants and command/status structs for greedy box nms
`default_nettype none
package gbn_pkg;
    localparam int MAX_BOXES = 64;
    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);

    localparam logic [0:0] REG_IOU_THRESHOLD = 1'd0;
    localparam logic [0:0] REG_KEEP_COUNT    = 1'd1;
    localparam logic [15:0] IOU_RESET = 16'd19661;
    localparam logic [6:0]  KEEP_RESET = 7'd64;

    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] box_score;
        logic        last_box;
    } box_in_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_top;
        logic [15:0] out_width;
        logic [15:0] out_height;
        logic [15:0] out_score;
        logic [5:0]  out_source;
        logic        box_valid;
        logic        set_overflow;
        logic        last_result;
    } box_out_t;

    // controller -> datapath
    typedef struct packed {
        logic             load;      // store input box at load index
        logic             sort_rd;   // read score of sorted[j-1] and cur
        logic             sort_mv;   // sorted[j] <= sorted[j-1]
        logic             sort_put;  // sorted[j] <= cur
        logic             sup_rd;    // read boxes a (sorted[i]) and b (kept[j])
        logic             sup_keep;  // kept[kept_total] <= a
        logic             out_phase; // box and score reads follow kept[k]
        logic             out_rd;    // read kept[k] box into output
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] ld_idx;
    } gbn_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic less;        // score[sorted[j-1]] < score[cur]
        logic suppress;    // overlap test true
    } gbn_sts_t;
endpackage
`default_nettype wire

@@ hdl/gbn_datapath.sv @@
// datapath: box memories, sort compare, overlap test pipeline, output fetch
`default_nettype none
module gbn_datapath (
    input  wire logic                   clk,
    input  wire gbn_pkg::box_in_t       in_box,
    input  wire gbn_pkg::gbn_cmd_t      cmd,
    input  wire logic [15:0]            iou_thr,
    output gbn_pkg::gbn_sts_t           sts,
    output logic [15:0]                 o_left,
    output logic [15:0]                 o_top,
    output logic [15:0]                 o_width,
    output logic [15:0]                 o_height,
    output logic [15:0]                 o_score,
    output logic [5:0]                  o_source
);
    import gbn_pkg::*;

    logic [63:0]      geo_mem [MAX_BOXES];
    logic [15:0]      score_mem [MAX_BOXES];
    logic [31:0]      area_mem [MAX_BOXES];
    logic [IDX_W-1:0] sort_mem [MAX_BOXES];
    logic [IDX_W-1:0] kept_mem [MAX_BOXES];

    // area multiply registered before storing
    logic [31:0]      ld_area_reg;
    logic [IDX_W-1:0] ld_idx_reg;
    logic             ld_pend_reg;

    always_ff @(posedge clk)
    begin
        ld_area_reg <= 32'(in_box.box_width) * 32'(in_box.box_height);
        ld_idx_reg  <= cmd.ld_idx;
        ld_pend_reg <= cmd.load;
        if (cmd.load)
        begin
            geo_mem[cmd.ld_idx] <= {in_box.box_height, in_box.box_width,
                                    in_box.box_top, in_box.box_left};
            score_mem[cmd.ld_idx] <= in_box.box_score;
        end
        if (ld_pend_reg)
            area_mem[ld_idx_reg] <= ld_area_reg;
    end

    // kept entry being emitted
    logic [IDX_W-1:0] s_reg;

    // sort: pointer fetch, then score fetch, then compare
    logic [IDX_W-1:0] prev_ptr_reg;
    logic [15:0]      sc_prev_reg, sc_cur_reg;
    always_ff @(posedge clk)
    begin
        prev_ptr_reg <= sort_mem[cmd.j - IDX_W'(1)];
        sc_prev_reg  <= score_mem[prev_ptr_reg];
        sc_cur_reg   <= score_mem[cmd.out_phase ? s_reg : cmd.i];
        if (cmd.sort_mv)
            sort_mem[cmd.j] <= prev_ptr_reg;
        else if (cmd.sort_put)
            sort_mem[cmd.j] <= cmd.i;
    end

    // suppression: index fetch, data fetch, overlap, multiply, union, threshold multiply, compare
    logic [IDX_W-1:0] a_reg, b_reg;
    logic [63:0]      ga_reg, gb_reg;
    logic [31:0]      aa_reg, ab_reg;
    always_ff @(posedge clk)
    begin
        a_reg  <= sort_mem[cmd.i];
        b_reg  <= kept_mem[cmd.j];
        ga_reg <= geo_mem[cmd.out_phase ? s_reg : a_reg];
        gb_reg <= geo_mem[b_reg];
        aa_reg <= area_mem[a_reg];
        ab_reg <= area_mem[b_reg];
        if (cmd.sup_keep)
            kept_mem[cmd.k] <= a_reg;
    end

    function automatic logic [16:0] ovl(input logic [15:0] a0, input logic [15:0] al,
                                        input logic [15:0] b0, input logic [15:0] bl);
        logic signed [17:0] sa, sb, ea, eb, lo, hi;
        sa = 18'(signed'(a0));
        sb = 18'(signed'(b0));
        ea = sa + signed'({2'b00, al});
        eb = sb + signed'({2'b00, bl});
        lo = (sa > sb) ? sa : sb;
        hi = (ea < eb) ? ea : eb;
        ovl = (hi > lo) ? 17'(hi - lo) : 17'd0;
    endfunction

    logic [16:0] w_reg, h_reg;
    logic [32:0] usum_reg;
    always_ff @(posedge clk)
    begin
        w_reg <= ovl(ga_reg[15:0], ga_reg[47:32], gb_reg[15:0], gb_reg[47:32]);
        h_reg <= ovl(ga_reg[31:16], ga_reg[63:48], gb_reg[31:16], gb_reg[63:48]);
        usum_reg <= {1'b0, aa_reg} + {1'b0, ab_reg};
    end

    logic [33:0] inter_reg;
    logic [32:0] usum2_reg;
    always_ff @(posedge clk)
    begin
        inter_reg <= 34'(w_reg) * 34'(h_reg);
        usum2_reg <= usum_reg;
    end

    // union stays within 33 bits since intersection never exceeds either area
    logic [32:0] uni_reg;
    logic [33:0] inter2_reg;
    always_ff @(posedge clk)
    begin
        uni_reg    <= 33'(usum2_reg - 33'(inter_reg));
        inter2_reg <= inter_reg;
    end

    // 16x33 product split into two narrow multiplies
    logic [32:0] plo_reg;
    logic [32:0] phi_reg;
    logic [49:0] inter3_reg;
    always_ff @(posedge clk)
    begin
        plo_reg    <= 33'(iou_thr) * 33'(uni_reg[16:0]);
        phi_reg    <= 33'(iou_thr) * 33'(uni_reg[32:17]);
        inter3_reg <= {inter2_reg, 16'd0};
    end

    logic [49:0] prod;
    assign prod = {phi_reg, 17'd0} + 50'(plo_reg);
    logic supp_reg;
    always_ff @(posedge clk)
        supp_reg <= inter3_reg > prod;
    assign sts = {sc_prev_reg < sc_cur_reg, supp_reg};

    // output fetch: kept index, then box and score, then output registers
    always_ff @(posedge clk)
    begin
        s_reg <= kept_mem[cmd.k];
        if (cmd.out_rd)
        begin
            o_left   <= ga_reg[15:0];
            o_top    <= ga_reg[31:16];
            o_width  <= ga_reg[47:32];
            o_height <= ga_reg[63:48];
            o_score  <= sc_cur_reg;
            o_source <= 6'(s_reg);
        end
    end
endmodule
`default_nettype wire

@@ hdl/gbn_ctrl.sv @@
// controller: load, insertion sort, suppression walk and result emission
`default_nettype none
module gbn_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire logic [6:0]         keep_cnt,
    input  wire gbn_pkg::gbn_sts_t  sts,
    output gbn_pkg::gbn_cmd_t       cmd,
    output logic                    o_box_valid,
    output logic                    o_overflow,
    output logic                    o_last
);
    import gbn_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_DRAIN, S_SI, S_SW, S_SC, S_PI, S_PW, S_PC, S_PN,
        S_OF, S_OW, S_OUT
    } st_t;

    localparam int SORT_LAT = 3;   // pointer, score, compare
    localparam int SUP_LAT  = 9;   // fetch pipeline into supp flag
    localparam int OUT_LAT  = 3;   // kept index, box, output registers

    st_t              st_reg;
    logic [CNT_W-1:0] cnt_reg;     // loaded boxes
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] kt_reg;      // kept total
    logic [CNT_W-1:0] k_reg;       // emit index
    logic [CNT_W-1:0] emit_reg;
    logic [3:0]       w_reg;
    logic             ovf_reg;
    logic             keep_reg;
    logic             bv_reg, last_reg, oval_reg;

    logic [CNT_W-1:0] kc;
    assign kc = (keep_cnt > 7'(MAX_BOXES)) ? MAX_CNT : CNT_W'(keep_cnt);

    assign in_ready  = (st_reg == S_LOAD);
    assign out_valid = oval_reg;
    assign o_box_valid = bv_reg;
    assign o_overflow  = ovf_reg;
    assign o_last      = last_reg;

    logic acc;
    assign acc = in_valid && in_ready;

    always_comb
    begin
        cmd = '0;
        cmd.i = IDX_W'(i_reg);
        cmd.j = IDX_W'(j_reg);
        cmd.k = (st_reg == S_PC) ? IDX_W'(kt_reg) : IDX_W'(k_reg);
        cmd.ld_idx = IDX_W'(cnt_reg);
        cmd.load = acc && (cnt_reg < MAX_CNT);
        cmd.sort_mv  = (st_reg == S_SC) && (j_reg != '0) && sts.less;
        cmd.sort_put = (st_reg == S_SC) && !((j_reg != '0) && sts.less);
        cmd.sort_rd  = (st_reg == S_SI);
        cmd.sup_rd   = (st_reg == S_PI);
        cmd.sup_keep = (st_reg == S_PC) && keep_reg && (kt_reg < MAX_CNT);
        cmd.out_phase = (st_reg == S_OF) || (st_reg == S_OW) || (st_reg == S_OUT);
        cmd.out_rd   = (st_reg == S_OW) && (w_reg == 4'(OUT_LAT - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_LOAD;
            cnt_reg <= '0; i_reg <= '0; j_reg <= '0; kt_reg <= '0;
            k_reg <= '0; emit_reg <= '0; w_reg <= '0;
            ovf_reg <= 1'b0; keep_reg <= 1'b0;
            bv_reg <= 1'b0; last_reg <= 1'b0; oval_reg <= 1'b0;
        end
        else
        begin
            case (st_reg)
                S_LOAD:
                    if (acc)
                    begin
                        if (cnt_reg < MAX_CNT)
                            cnt_reg <= cnt_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                        if (in_last)
                        begin
                            i_reg <= '0;
                            st_reg <= S_DRAIN;
                        end
                    end
                S_DRAIN:
                    // area write lands in the cycle after load
                    begin
                        if (i_reg == cnt_reg)
                        begin
                            i_reg <= '0; kt_reg <= '0;
                            st_reg <= S_PI;
                        end
                        else
                        begin
                            j_reg <= i_reg;
                            st_reg <= S_SI;
                        end
                    end
                S_SI:
                    begin
                        w_reg <= '0;
                        st_reg <= S_SW;
                    end
                S_SW:
                    if (w_reg == 4'(SORT_LAT - 2))
                        st_reg <= S_SC;
                    else
                        w_reg <= w_reg + 1'b1;
                S_SC:
                    if ((j_reg != '0) && sts.less)
                    begin
                        j_reg <= j_reg - 1'b1;
                        st_reg <= S_SI;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        st_reg <= S_DRAIN;
                    end
                S_PI:
                    if (i_reg == cnt_reg)
                    begin
                        emit_reg <= (kt_reg > kc) ? kc : kt_reg;
                        k_reg <= '0;
                        st_reg <= S_OF;
                    end
                    else
                    begin
                        j_reg <= '0; keep_reg <= 1'b1;
                        if (kt_reg == '0)
                            st_reg <= S_PC;
                        else
                        begin
                            w_reg <= '0;
                            st_reg <= S_PW;
                        end
                    end
                S_PW:
                    if (w_reg == 4'(SUP_LAT - 1))
                    begin
                        if (sts.suppress)
                            keep_reg <= 1'b0;
                        if (j_reg + 1'b1 == kt_reg)
                            st_reg <= S_PC;
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                            w_reg <= '0;
                            st_reg <= S_PN;
                        end
                    end
                    else
                        w_reg <= w_reg + 1'b1;
                S_PN:
                    // restart fetch for next kept entry
                    st_reg <= S_PW;
                S_PC:
                    begin
                        if (keep_reg && (kt_reg < MAX_CNT))
                            kt_reg <= kt_reg + 1'b1;
                        i_reg <= i_reg + 1'b1;
                        st_reg <= S_PI;
                    end
                S_OF:
                    if (emit_reg == '0)
                    begin
                        bv_reg <= 1'b0; last_reg <= 1'b1; oval_reg <= 1'b1;
                        st_reg <= S_OUT;
                    end
                    else
                    begin
                        w_reg <= '0;
                        st_reg <= S_OW;
                    end
                S_OW:
                    if (w_reg == 4'(OUT_LAT - 1))
                    begin
                        bv_reg <= 1'b1;
                        last_reg <= (k_reg + 1'b1 == emit_reg);
                        oval_reg <= 1'b1;
                        st_reg <= S_OUT;
                    end
                    else
                        w_reg <= w_reg + 1'b1;
                S_OUT:
                    if (out_ready)
                    begin
                        oval_reg <= 1'b0;
                        if (last_reg)
                        begin
                            cnt_reg <= '0; kt_reg <= '0; ovf_reg <= 1'b0;
                            st_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            w_reg <= '0;
                            st_reg <= S_OW;
                        end
                    end
                default:
                    st_reg <= S_LOAD;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_LOAD) |-> !in_ready)
        else $error("input taken while busy");
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("load count above capacity");
    a_kept_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        kt_reg <= cnt_reg)
        else $error("kept more than loaded");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && !out_ready) |=> (oval_reg && $stable(last_reg)))
        else $error("result dropped");
endmodule
`default_nettype wire

@@ hdl/greedy_box_nms.sv @@
// top level of greedy box non-maximum suppression
//
// Boxes load one per cycle until the box flagged last_box; up to MAX_BOXES are
// kept, the rest dropped and flagged by set_overflow. After the last box the
// block sorts by descending score with an insertion sort (ties stay in load
// order), then walks the greedy suppression: each candidate is tested against
// every kept box through a 7-stage fetch/overlap/multiply pipeline that the
// controller waits out. A box is dropped when intersection*65536 >
// iou_threshold*union. Results then stream out, each fetched only after the
// previous one transfers, at most keep_count of them; an empty answer is one
// result with box_valid low. Input is held off (ready low) from the last box
// until the final result transfers. The user must make configuration writes
// only when idle; the block itself does not enforce this.
`default_nettype none
module greedy_box_nms (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire gbn_pkg::box_in_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output gbn_pkg::box_out_t       out_data,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import gbn_pkg::*;

    // configuration registers
    logic [15:0] iou_reg;
    logic [6:0]  keep_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iou_reg  <= IOU_RESET;
            keep_reg <= KEEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IOU_THRESHOLD: iou_reg  <= cfg_data;
                REG_KEEP_COUNT:    keep_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    gbn_cmd_t cmd;
    gbn_sts_t sts;
    logic bv, ovf, lst;
    logic [15:0] l, t, w, h, s;
    logic [5:0] src;

    gbn_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_last(in_data.last_box),
        .out_valid(out_valid), .out_ready(out_ready),
        .keep_cnt(keep_reg), .sts(sts), .cmd(cmd),
        .o_box_valid(bv), .o_overflow(ovf), .o_last(lst)
    );

    gbn_datapath u_dp (
        .clk(clk), .in_box(in_data), .cmd(cmd), .iou_thr(iou_reg), .sts(sts),
        .o_left(l), .o_top(t), .o_width(w), .o_height(h), .o_score(s),
        .o_source(src)
    );

    // empty answer carries zero payload
    always_comb
    begin
        out_data = '0;
        out_data.box_valid    = bv;
        out_data.set_overflow = ovf;
        out_data.last_result  = lst;
        if (bv)
        begin
            out_data.out_left   = l;
            out_data.out_top    = t;
            out_data.out_width  = w;
            out_data.out_height = h;
            out_data.out_score  = s;
            out_data.out_source = src;
        end
    end
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench for greedy_box_nms: directed sets, random sets, scoreboard against a predictor
`default_nettype none
module testbench;
    import gbn_pkg::*;

    localparam int EXP_DEPTH = 128;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    box_in_t in_data;
    logic out_valid;
    logic out_ready;
    box_out_t out_data;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [15:0] cfg_data;

    greedy_box_nms u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the block state
    logic [15:0] thr_q;
    logic [6:0]  keep_q;
    box_in_t     set_box [MAX_BOXES];
    int          set_len;
    bit          set_ovf;

    // expected results, written by the predictor and read by the checker
    box_out_t exp_mem [EXP_DEPTH];
    int       exp_wr;
    int       exp_rd;
    int       errors;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // generous fixed time limit, sized for the worst set's sort and suppression walk
    initial
    begin
        #20000000;
        $display("greedy_box_nms: mismatch");
        $finish;
    end

    function automatic longint unsigned overlap(longint a0, longint alen,
                                                longint b0, longint blen);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = ((a0 + alen) < (b0 + blen)) ? (a0 + alen) : (b0 + blen);
        return (hi > lo) ? longint'(hi - lo) : 0;
    endfunction

    task automatic exp_put(box_out_t r);
        exp_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    // sort, suppress and queue the expected results of the closed set
    task automatic close_set();
        int order[MAX_BOXES];
        int kept[MAX_BOXES];
        int nkept;
        int cur;
        int j;
        int emit;
        bit keep;
        longint unsigned w;
        longint unsigned h;
        longint unsigned inter;
        longint unsigned uni;
        longint unsigned area_a;
        longint unsigned area_b;
        box_in_t a;
        box_in_t b;
        box_out_t r;
        // insertion sort, stable for equal scores
        for (int i = 0; i < set_len; i++)
        begin
            cur = i;
            j = i;
            while (j > 0 && set_box[order[j-1]].box_score < set_box[cur].box_score)
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        nkept = 0;
        for (int i = 0; i < set_len; i++)
        begin
            a = set_box[order[i]];
            keep = 1'b1;
            for (int m = 0; m < nkept; m++)
            begin
                b = set_box[kept[m]];
                w = overlap(a.box_left, a.box_width, b.box_left, b.box_width);
                h = overlap(a.box_top, a.box_height, b.box_top, b.box_height);
                inter = (w == 0 || h == 0) ? 0 : w * h;
                area_a = a.box_width * a.box_height;
                area_b = b.box_width * b.box_height;
                uni = area_a + area_b - inter;
                if ((inter << 16) > longint'(thr_q) * uni)
                    keep = 1'b0;
            end
            if (keep)
            begin
                kept[nkept] = order[i];
                nkept++;
            end
        end
        emit = (keep_q > MAX_BOXES) ? MAX_BOXES : keep_q;
        if (emit > nkept)
            emit = nkept;
        if (emit == 0)
        begin
            r = '0;
            r.set_overflow = set_ovf;
            r.last_result = 1'b1;
            exp_put(r);
        end
        for (int k = 0; k < emit; k++)
        begin
            a = set_box[kept[k]];
            r.out_left = a.box_left;
            r.out_top = a.box_top;
            r.out_width = a.box_width;
            r.out_height = a.box_height;
            r.out_score = a.box_score;
            r.out_source = 6'(kept[k]);
            r.box_valid = 1'b1;
            r.set_overflow = set_ovf;
            r.last_result = (k == emit - 1);
            exp_put(r);
        end
        set_len = 0;
        set_ovf = 1'b0;
    endtask

    task automatic predict_box(box_in_t bx);
        if (set_len < MAX_BOXES)
        begin
            set_box[set_len] = bx;
            set_len++;
        end
        else
            set_ovf = 1'b1;
        if (bx.last_box)
            close_set();
    endtask

    // one input transfer with a random gap before it
    task automatic send_box(box_in_t bx);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= bx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_box(bx);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        in_valid <= 1'b0;
        // let the block settle before touching registers
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IOU_THRESHOLD)
            thr_q = val;
        else
            keep_q = val[6:0];
    endtask

    function automatic box_in_t mk(int l, int t, int w, int h, int s, bit lst);
        box_in_t bx;
        bx.box_left = 16'(l);
        bx.box_top = 16'(t);
        bx.box_width = 16'(w);
        bx.box_height = 16'(h);
        bx.box_score = 16'(s);
        bx.last_box = lst;
        return bx;
    endfunction

    function automatic box_in_t rand_box(bit lst, int spread);
        box_in_t bx;
        bx.box_left = 16'($urandom_range(0, spread) - spread / 2);
        bx.box_top = 16'($urandom_range(0, spread) - spread / 2);
        bx.box_width = 16'($urandom_range(0, spread / 2));
        bx.box_height = 16'($urandom_range(0, spread / 2));
        bx.box_score = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                                  : 16'($urandom);
        bx.last_box = lst;
        return bx;
    endfunction

    // output side: field compare against the oldest expectation
    always @(posedge clk)
    begin
        box_out_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_wr == exp_rd)
            begin
                $error("unexpected result transfer %p", out_data);
                errors++;
            end
            else
            begin
                exp_r = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (out_data.out_left !== exp_r.out_left)
                begin
                    $error("out_left exp %0h got %0h", exp_r.out_left, out_data.out_left);
                    errors++;
                end
                if (out_data.out_top !== exp_r.out_top)
                begin
                    $error("out_top exp %0h got %0h", exp_r.out_top, out_data.out_top);
                    errors++;
                end
                if (out_data.out_width !== exp_r.out_width)
                begin
                    $error("out_width exp %0h got %0h", exp_r.out_width,
                           out_data.out_width);
                    errors++;
                end
                if (out_data.out_height !== exp_r.out_height)
                begin
                    $error("out_height exp %0h got %0h", exp_r.out_height,
                           out_data.out_height);
                    errors++;
                end
                if (out_data.out_score !== exp_r.out_score)
                begin
                    $error("out_score exp %0h got %0h", exp_r.out_score,
                           out_data.out_score);
                    errors++;
                end
                if (out_data.out_source !== exp_r.out_source)
                begin
                    $error("out_source exp %0d got %0d", exp_r.out_source,
                           out_data.out_source);
                    errors++;
                end
                if (out_data.box_valid !== exp_r.box_valid)
                begin
                    $error("box_valid exp %0b got %0b", exp_r.box_valid,
                           out_data.box_valid);
                    errors++;
                end
                if (out_data.set_overflow !== exp_r.set_overflow)
                begin
                    $error("set_overflow exp %0b got %0b", exp_r.set_overflow,
                           out_data.set_overflow);
                    errors++;
                end
                if (out_data.last_result !== exp_r.last_result)
                begin
                    $error("last_result exp %0b got %0b", exp_r.last_result,
                           out_data.last_result);
                    errors++;
                end
            end
        end
    end

    // ready dropped for a random gap before each result
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // directed table: geometry extremes, ties, overlap and no-overlap pairs
    box_in_t dir_tab[] = '{
        mk(-32768, -32768, 65535, 65535, 65535, 1'b0),
        mk(32767, 32767, 0, 0, 0, 1'b0),
        mk(0, 0, 160, 160, 40000, 1'b0),
        mk(16, 16, 160, 160, 40000, 1'b0),      // equal score, heavy overlap
        mk(1000, 1000, 64, 64, 30000, 1'b0),    // disjoint
        mk(1064, 1000, 64, 64, 50000, 1'b0),    // touching edge, zero overlap
        mk(0, 0, 0, 160, 100, 1'b1),            // zero width box closes the set
        mk(5, 5, 10, 10, 7, 1'b1)               // single-box set
    };

    int n_items;
    int set_size;
    bit lst;

    initial
    begin
        errors = 0;
        exp_wr = 0;
        exp_rd = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_IOU_THRESHOLD;
        cfg_data = '0;
        thr_q = IOU_RESET;
        keep_q = KEEP_RESET;
        set_len = 0;
        set_ovf = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // an all-zero box right after reset joins the first directed set
        send_box(mk(0, 0, 0, 0, 0, 1'b0));
        foreach (dir_tab[i])
            send_box(dir_tab[i]);

        // keep_count zero gives the empty answer
        write_reg(REG_KEEP_COUNT, 16'd0);
        send_box(mk(1, 2, 3, 4, 5, 1'b1));
        // extremes of both registers
        write_reg(REG_KEEP_COUNT, 16'hFFFF);
        write_reg(REG_IOU_THRESHOLD, 16'd0);
        foreach (dir_tab[i])
            send_box(dir_tab[i]);
        write_reg(REG_IOU_THRESHOLD, 16'hFFFF);
        foreach (dir_tab[i])
            send_box(dir_tab[i]);

        // overflow: 66 boxes, the last one dropped too
        write_reg(REG_IOU_THRESHOLD, IOU_RESET);
        write_reg(REG_KEEP_COUNT, 16'd64);
        for (int i = 0; i < 66; i++)
            send_box(rand_box(i == 65, 65535));

        // random sets, mostly small, with register changes between phases
        n_items = 0;
        while (n_items < 380)
        begin
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_IOU_THRESHOLD, 16'($urandom));
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_KEEP_COUNT, 16'($urandom_range(0, 70)));
            set_size = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 64)
                                                    : $urandom_range(1, 10);
            for (int i = 0; i < set_size; i++)
            begin
                lst = (i == set_size - 1);
                send_box(rand_box(lst, ($urandom_range(0, 3) == 0) ? 65535 : 800));
                n_items++;
            end
        end
        in_valid <= 1'b0;

        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("greedy_box_nms: match");
        else
            $display("greedy_box_nms: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

@@ greedy_box_nms.f @@
hdl/gbn_pkg.sv
hdl/gbn_datapath.sv
hdl/gbn_ctrl.sv
hdl/greedy_box_nms.sv
tb/sv/testbench.sv
